// ----- src/jss_pkg.sv -----
// Shared types and constants for the Jacobi stencil sweep.
// No dependencies; every other file except jss_line_buf imports this package.
package jss_pkg;

  localparam int unsigned IDX_W    = 10;
  localparam int unsigned CFG_W    = 11;
  localparam int unsigned MIN_SIDE = 4;
  localparam int unsigned GRID_RST = 1024;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CFG_W-1:0] cfg_t;

  typedef enum logic [1:0] {
    CNT3 = 2'd0,
    CNT4 = 2'd1,
    CNT5 = 2'd2
  } count_e;

  typedef struct packed {
    idx_t row;
    idx_t col;
    logic done;
  } tag_t;

endpackage

// ----- src/jss_if.sv -----
// Valid/ready channels of the stencil sweep: cell stream in, result stream out.
// Depends on jss_pkg.
interface jss_cell_if #(
  parameter int unsigned VW = 32
) ();
  logic                 valid;
  logic                 ready;
  logic signed [VW-1:0] cell_value;

  modport source (output valid, output cell_value, input ready);
  modport sink   (input valid, input cell_value, output ready);
endinterface

interface jss_result_if import jss_pkg::*; #(
  parameter int unsigned VW = 32
) ();
  logic                 valid;
  logic                 ready;
  logic signed [VW-1:0] new_value;
  idx_t                 cell_row;
  idx_t                 cell_col;
  logic                 pass_done;
  logic [VW-1:0]        max_change;

  modport source (output valid, output new_value, output cell_row, output cell_col,
                  output pass_done, output max_change, input ready);
  modport sink   (input valid, input new_value, input cell_row, input cell_col,
                  input pass_done, input max_change, output ready);
endinterface

// ----- src/jss_line_buf.sv -----
// Two line buffers (middle and above rows) in synchronous RAM with registered read.
// Middle row has two read ports (centre and right neighbour). Depends on nothing.
module jss_line_buf #(
  parameter  int unsigned DEPTH = 1024,
  parameter  int unsigned VW    = 32,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [AW-1:0]        wr_addr_i,
  input  logic signed [VW-1:0] mid_wdata_i,
  input  logic signed [VW-1:0] above_wdata_i,
  input  logic [AW-1:0]        rd_addr_i,
  output logic signed [VW-1:0] centre_o,
  output logic signed [VW-1:0] right_o,
  output logic signed [VW-1:0] above_o
);

  logic signed [VW-1:0] mid_mem   [DEPTH];
  logic signed [VW-1:0] above_mem [DEPTH];
  logic [AW-1:0]        rd_addr_right;

  assign rd_addr_right = rd_addr_i + AW'(1);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mid_mem[wr_addr_i] <= mid_wdata_i;
      centre_o           <= mid_mem[rd_addr_i];
      right_o            <= mid_mem[rd_addr_right];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      above_mem[wr_addr_i] <= above_wdata_i;
      above_o              <= above_mem[rd_addr_i];
    end
  end

endmodule

// ----- src/jss_divider.sv -----
// Pipelined divide of the stencil sum by 3, 4 or 5 via reciprocal multiply,
// with saturation and absolute change. Depends on jss_pkg.
module jss_divider import jss_pkg::*; #(
  parameter  int unsigned VW    = 32,
  localparam int unsigned SUM_W = VW + 3
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [SUM_W-1:0] sum_i,
  input  logic signed [VW-1:0]    centre_i,
  input  count_e                  cnt_i,
  input  tag_t                    tag_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [VW-1:0]    nv_o,
  output logic [VW-1:0]           ad_o,
  output tag_t                    tag_o
);

  localparam int unsigned MAG_W  = VW + 2;
  localparam int unsigned K      = VW + 5;
  localparam int unsigned MLO    = MAG_W / 2;
  localparam int unsigned MHI    = MAG_W - MLO;
  localparam int unsigned RLO    = K / 2;
  localparam int unsigned RHI    = K - RLO;
  localparam int unsigned PROD_W = MAG_W + K;

  localparam logic [K:0]       POW_K  = {1'b1, {K{1'b0}}};
  localparam logic [K-1:0]     RECIP3 = K'((POW_K + (K+1)'(2)) / (K+1)'(3));
  localparam logic [K-1:0]     RECIP4 = K'(POW_K >> 2);
  localparam logic [K-1:0]     RECIP5 = K'((POW_K + (K+1)'(4)) / (K+1)'(5));
  localparam logic [MAG_W-1:0] QMAX_POS = MAG_W'({1'b0, {(VW-1){1'b1}}});
  localparam logic [MAG_W-1:0] QMAX_NEG = MAG_W'({1'b1, {(VW-1){1'b0}}});

  logic [6:1] v_q;
  logic [6:1] rdy;

  logic signed [SUM_W-1:0] sum1_q;
  logic signed [VW-1:0]    ctr1_q, ctr2_q, ctr3_q, ctr4_q, ctr5_q;
  count_e                  cnt1_q;
  tag_t                    tag1_q, tag2_q, tag3_q, tag4_q, tag5_q, tag6_q;
  logic                    neg2_q, neg3_q, neg4_q;
  logic [MAG_W-1:0]        mag2_q, q4_q;
  logic [K-1:0]            rcp2_q;
  logic [MLO+RLO-1:0]      pp_ll_q;
  logic [MLO+RHI-1:0]      pp_lh_q;
  logic [MHI+RLO-1:0]      pp_hl_q;
  logic [MHI+RHI-1:0]      pp_hh_q;
  logic signed [VW-1:0]    nv5_q, nv6_q;
  logic [VW-1:0]           ad6_q;

  logic [SUM_W-1:0]  sum_neg;
  logic [MAG_W-1:0]  mag_d;
  logic [K-1:0]      rcp_d;
  logic [PROD_W-1:0] prod;
  logic [MAG_W-1:0]  q_neg;
  logic signed [VW-1:0] nv_d;
  logic [VW:0]       diff_a, diff_b;

  always_comb begin
    rdy[6] = !v_q[6] || out_ready_i;
    for (int k = 5; k >= 1; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign in_ready_o  = rdy[1];
  assign out_valid_o = v_q[6];
  assign nv_o        = nv6_q;
  assign ad_o        = ad6_q;
  assign tag_o       = tag6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[1]) begin
        v_q[1] <= in_valid_i;
      end
      for (int k = 2; k <= 6; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // magnitude and reciprocal
  always_comb begin
    sum_neg = -sum1_q;
    mag_d   = sum1_q[SUM_W-1] ? sum_neg[MAG_W-1:0] : sum1_q[MAG_W-1:0];
    case (cnt1_q)
      CNT3:    rcp_d = RECIP3;
      CNT4:    rcp_d = RECIP4;
      default: rcp_d = RECIP5;
    endcase
  end

  // recombine partial products
  assign prod = PROD_W'(pp_ll_q)
              + (PROD_W'(pp_lh_q) << RLO)
              + (PROD_W'(pp_hl_q) << MLO)
              + (PROD_W'(pp_hh_q) << (MLO + RLO));

  // saturate and restore sign
  always_comb begin
    q_neg = ~q4_q + MAG_W'(1);
    if (neg4_q) begin
      nv_d = (q4_q > QMAX_NEG) ? {1'b1, {(VW-1){1'b0}}} : q_neg[VW-1:0];
    end else begin
      nv_d = (q4_q > QMAX_POS) ? {1'b0, {(VW-1){1'b1}}} : q4_q[VW-1:0];
    end
  end

  assign diff_a = {nv5_q[VW-1], nv5_q} - {ctr5_q[VW-1], ctr5_q};
  assign diff_b = {ctr5_q[VW-1], ctr5_q} - {nv5_q[VW-1], nv5_q};

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      sum1_q <= sum_i;
      ctr1_q <= centre_i;
      cnt1_q <= cnt_i;
      tag1_q <= tag_i;
    end
    if (rdy[2]) begin
      neg2_q <= sum1_q[SUM_W-1];
      mag2_q <= mag_d;
      rcp2_q <= rcp_d;
      ctr2_q <= ctr1_q;
      tag2_q <= tag1_q;
    end
    if (rdy[3]) begin
      pp_ll_q <= (MLO+RLO)'(mag2_q[MLO-1:0])     * (MLO+RLO)'(rcp2_q[RLO-1:0]);
      pp_lh_q <= (MLO+RHI)'(mag2_q[MLO-1:0])     * (MLO+RHI)'(rcp2_q[K-1:RLO]);
      pp_hl_q <= (MHI+RLO)'(mag2_q[MAG_W-1:MLO]) * (MHI+RLO)'(rcp2_q[RLO-1:0]);
      pp_hh_q <= (MHI+RHI)'(mag2_q[MAG_W-1:MLO]) * (MHI+RHI)'(rcp2_q[K-1:RLO]);
      neg3_q  <= neg2_q;
      ctr3_q  <= ctr2_q;
      tag3_q  <= tag2_q;
    end
    if (rdy[4]) begin
      q4_q   <= prod[PROD_W-1:K];
      neg4_q <= neg3_q;
      ctr4_q <= ctr3_q;
      tag4_q <= tag3_q;
    end
    if (rdy[5]) begin
      nv5_q  <= nv_d;
      ctr5_q <= ctr4_q;
      tag5_q <= tag4_q;
    end
    if (rdy[6]) begin
      nv6_q  <= nv5_q;
      ad6_q  <= diff_a[VW] ? diff_b[VW-1:0] : diff_a[VW-1:0];
      tag6_q <= tag5_q;
    end
  end

endmodule

// ----- src/jss_report.sv -----
// Output register of the sweep: running maximum of change and end-of-pass report.
// Depends on jss_pkg and jss_result_if.
module jss_report import jss_pkg::*; #(
  parameter int unsigned VW = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 restart_i,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic signed [VW-1:0] nv_i,
  input  logic [VW-1:0]        ad_i,
  input  tag_t                 tag_i,
  jss_result_if.source         out_if
);

  logic                 ov_q;
  logic [VW-1:0]        max_q;
  logic signed [VW-1:0] nv_q;
  idx_t                 row_q;
  idx_t                 col_q;
  logic                 done_q;
  logic [VW-1:0]        mx_q;
  logic                 load;

  assign ready_o = !ov_q || out_if.ready;
  assign load    = valid_i && ready_o;

  assign out_if.valid      = ov_q;
  assign out_if.new_value  = nv_q;
  assign out_if.cell_row   = row_q;
  assign out_if.cell_col   = col_q;
  assign out_if.pass_done  = done_q;
  assign out_if.max_change = mx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q  <= 1'b0;
      max_q <= '0;
    end else begin
      if (ready_o) begin
        ov_q <= valid_i;
      end
      if (restart_i) begin
        max_q <= '0;
      end else if (load) begin
        if (tag_i.done) begin
          max_q <= '0;
        end else if (ad_i > max_q) begin
          max_q <= ad_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (tag_i.done) begin
        nv_q   <= '0;
        row_q  <= '0;
        col_q  <= '0;
        done_q <= 1'b1;
        mx_q   <= max_q;
      end else begin
        nv_q   <= nv_i;
        row_q  <= tag_i.row;
        col_q  <= tag_i.col;
        done_q <= 1'b0;
        mx_q   <= '0;
      end
    end
  end

endmodule

// ----- src/jacobi_stencil_sweep.sv -----
// Jacobi 5-point stencil sweep: one cell per cycle unless the divider stalls the input.
// Line-buffer RAMs are read one column ahead on every accepted item.
// Reset clears position, pass maximum and pipeline; grid side goes to min(1024, MAX_SIDE).
// Line-buffer contents are not cleared: rows are written before they are read.
// Depends on jss_pkg, jss_if, jss_line_buf, jss_divider and jss_report.
module jacobi_stencil_sweep import jss_pkg::*; #(
  parameter int unsigned MAX_SIDE    = 1024,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  cfg_t          cfg_wdata_i,
  jss_cell_if.sink      in_if,
  jss_result_if.source  out_if
);

  localparam int unsigned AW       = $clog2(MAX_SIDE);
  localparam int unsigned SUM_W    = VALUE_WIDTH + 3;
  localparam int unsigned SIDE_W   = AW + 1;
  localparam int unsigned CMP_W    = (SIDE_W > CFG_W) ? SIDE_W : CFG_W;
  localparam int unsigned RST_SIDE = (GRID_RST > MAX_SIDE) ? MAX_SIDE : GRID_RST;
  localparam logic [CMP_W-1:0] MAX_SIDE_C = CMP_W'(MAX_SIDE);
  localparam logic [CMP_W-1:0] MIN_SIDE_C = CMP_W'(MIN_SIDE);

  logic [AW-1:0] lim_q, lim_d, lim_m1;
  logic [AW-1:0] row_q, row_d, col_q, col_d;
  logic signed [VALUE_WIDTH-1:0] left_q;
  logic [CMP_W-1:0] grid_ext, side_w;

  logic acc, last_col, last_row, emit, done_tok;
  logic [3:0] nb;
  logic [2:0] nb_cnt;
  count_e     cnt;
  tag_t       tag;

  logic signed [VALUE_WIDTH-1:0] centre, right, above;
  logic signed [SUM_W-1:0]       sum;

  logic                          div_ready, div_valid;
  logic signed [VALUE_WIDTH-1:0] div_nv;
  logic [VALUE_WIDTH-1:0]        div_ad;
  tag_t                          div_tag;
  logic                          rep_ready;
  logic                          rep_valid;

  assign grid_ext = CMP_W'(cfg_wdata_i);

  always_comb begin
    side_w = grid_ext;
    if (grid_ext < MIN_SIDE_C) begin
      side_w = MIN_SIDE_C;
    end else if (grid_ext > MAX_SIDE_C) begin
      side_w = MAX_SIDE_C;
    end
    lim_d = AW'(side_w - CMP_W'(1));
  end

  assign in_if.ready = div_ready;
  assign acc         = in_if.valid && div_ready;

  assign lim_m1   = lim_q - AW'(1);
  assign last_col = (col_q == lim_q);
  assign last_row = (row_q == lim_q);
  assign emit     = (row_q >= AW'(2)) && (col_q != '0) && (col_q < lim_q);
  assign done_tok = last_col && last_row;

  assign nb     = {col_q > AW'(1), row_q > AW'(2), col_q < lim_m1, row_q < lim_q};
  assign nb_cnt = 3'($countones(nb));

  always_comb begin
    case (nb_cnt)
      3'd2:    cnt = CNT3;
      3'd3:    cnt = CNT4;
      default: cnt = CNT5;
    endcase
  end

  always_comb begin
    col_d = col_q + AW'(1);
    row_d = row_q;
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : row_q + AW'(1);
    end
  end

  assign sum = SUM_W'(centre) + SUM_W'(left_q) + SUM_W'(right) + SUM_W'(above)
             + SUM_W'(in_if.cell_value);

  assign tag.row  = IDX_W'(row_q - AW'(1));
  assign tag.col  = IDX_W'(col_q);
  assign tag.done = done_tok;

  assign div_valid = in_if.valid && (emit || done_tok);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q  <= AW'(RST_SIDE - 1);
      row_q  <= '0;
      col_q  <= '0;
      left_q <= '0;
    end else if (cfg_we_i) begin
      lim_q  <= lim_d;
      row_q  <= '0;
      col_q  <= '0;
      left_q <= '0;
    end else if (acc) begin
      row_q  <= row_d;
      col_q  <= col_d;
      left_q <= centre;
    end
  end

  jss_line_buf #(
    .DEPTH (MAX_SIDE),
    .VW    (VALUE_WIDTH)
  ) u_line_buf (
    .clk_i         (clk_i),
    .en_i          (acc),
    .wr_addr_i     (col_q),
    .mid_wdata_i   (in_if.cell_value),
    .above_wdata_i (centre),
    .rd_addr_i     (col_d),
    .centre_o      (centre),
    .right_o       (right),
    .above_o       (above)
  );

  jss_divider #(
    .VW (VALUE_WIDTH)
  ) u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (div_valid),
    .in_ready_o  (div_ready),
    .sum_i       (sum),
    .centre_i    (centre),
    .cnt_i       (cnt),
    .tag_i       (tag),
    .out_valid_o (rep_valid),
    .out_ready_i (rep_ready),
    .nv_o        (div_nv),
    .ad_o        (div_ad),
    .tag_o       (div_tag)
  );

  jss_report #(
    .VW (VALUE_WIDTH)
  ) u_report (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (cfg_we_i),
    .valid_i   (rep_valid),
    .ready_o   (rep_ready),
    .nv_i      (div_nv),
    .ad_i      (div_ad),
    .tag_i     (div_tag),
    .out_if    (out_if)
  );

endmodule

// ----- src/jss_checker.sv -----
// Port-level checks on the result stream of the stencil sweep, bound to the top level.
// Depends on jss_pkg and jacobi_stencil_sweep.
module jss_checker import jss_pkg::*; #(
  parameter int unsigned VW = 32
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_i,
  input logic          out_ready_i,
  input logic [VW-1:0] new_value_i,
  input idx_t          cell_row_i,
  input idx_t          cell_col_i,
  input logic          pass_done_i,
  input logic [VW-1:0] max_change_i
);

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item dropped while stalled");

  a_hold_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(new_value_i) && $stable(cell_row_i)
      && $stable(cell_col_i) && $stable(pass_done_i) && $stable(max_change_i))
    else $error("stalled result item changed");

  a_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && pass_done_i |-> new_value_i == '0 && cell_row_i == '0
      && cell_col_i == '0)
    else $error("end-of-pass report carries a cell");

  a_cell_nomax: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !pass_done_i |-> max_change_i == '0)
    else $error("cell result carries a maximum");

endmodule

bind jacobi_stencil_sweep jss_checker #(
  .VW (VALUE_WIDTH)
) u_jss_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_if.valid),
  .out_ready_i  (out_if.ready),
  .new_value_i  (out_if.new_value),
  .cell_row_i   (out_if.cell_row),
  .cell_col_i   (out_if.cell_col),
  .pass_done_i  (out_if.pass_done),
  .max_change_i (out_if.max_change)
);

// ----- tb/jacobi_stencil_sweep_test.sv -----
// Self-checking bench for jacobi_stencil_sweep: streams grid cells, predicts every stencil
// update and end-of-pass report, and compares them field by field on the result channel.
// Depends on jss_pkg, jss_if and the jacobi_stencil_sweep RTL.
module jacobi_stencil_sweep_test import jss_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VW           = 32;
  localparam int unsigned SIDE_MAX     = 1024;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned RANDOM_CELLS = 200;
  localparam longint unsigned POS_LIMIT = (64'd1 << (VW - 1)) - 1;
  localparam longint unsigned NEG_LIMIT = 64'd1 << (VW - 1);
  localparam logic signed [VW-1:0] POS_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] NEG_MIN = {1'b1, {(VW-1){1'b0}}};

  typedef struct packed {
    logic [VW-1:0] value;
    idx_t          row;
    idx_t          col;
    logic          done;
    logic [VW-1:0] peak;
  } sweep_result_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  cfg_t cfg_wdata;

  jss_cell_if   #(.VW(VW)) cell_ch ();
  jss_result_if #(.VW(VW)) sweep_ch ();

  jacobi_stencil_sweep #(
    .MAX_SIDE   (SIDE_MAX),
    .VALUE_WIDTH(VW)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_if      (cell_ch),
    .out_if     (sweep_ch)
  );

  // predictor state
  logic signed [VW-1:0] above_row [SIDE_MAX];
  logic signed [VW-1:0] middle_row [SIDE_MAX];
  logic signed [VW-1:0] left_hold;
  cfg_t                 grid_cfg;
  int unsigned          row_pos;
  int unsigned          col_pos;
  longint unsigned      pass_peak;

  sweep_result_t expected_results[$];
  sweep_result_t want;
  int unsigned   mismatches;
  int unsigned   cells_sent;
  int unsigned   result_hold;
  bit            idle_on;
  bit            stall_on;

  always #4 clk_i = ~clk_i;

  function automatic void restart_sweep();
    row_pos   = 0;
    col_pos   = 0;
    pass_peak = 0;
    left_hold = '0;
  endfunction

  function automatic int unsigned grid_side();
    if (grid_cfg < MIN_SIDE) return MIN_SIDE;
    if (grid_cfg > SIDE_MAX) return SIDE_MAX;
    return 32'(grid_cfg);
  endfunction

  function automatic void predict_cell(input logic signed [VW-1:0] x);
    int unsigned          s;
    int unsigned          r;
    int unsigned          c;
    int unsigned          cr;
    int unsigned          count;
    logic signed [VW-1:0] old_mid;
    longint               total;
    longint               quot;
    longint               delta;
    longint unsigned      mag;
    bit                   emitted;
    sweep_result_t        res;
    s = grid_side();
    r = row_pos;
    c = col_pos;
    emitted = 1'b0;
    if (r >= s) r = s - 1;
    if (c >= s) c = s - 1;
    old_mid = middle_row[c];
    if (r >= 2 && c >= 1 && c <= s - 2) begin
      cr = r - 1;
      count = 1 + int'(c > 1) + int'(cr > 1) + int'(c < s - 2) + int'(cr < s - 2);
      total = longint'(old_mid) + longint'(left_hold) + longint'(middle_row[c+1])
            + longint'(above_row[c]) + longint'(x);
      if (total < 0) begin
        mag = longint'(0) - total;
        mag = mag / count;
        if (mag > NEG_LIMIT) mag = NEG_LIMIT;
        quot = longint'(0) - longint'(mag);
      end else begin
        mag = total;
        mag = mag / count;
        if (mag > POS_LIMIT) mag = POS_LIMIT;
        quot = longint'(mag);
      end
      delta = quot - longint'(old_mid);
      mag = (delta < 0) ? longint'(0) - delta : delta;
      if (mag > pass_peak) pass_peak = mag;
      res.value = quot[VW-1:0];
      res.row   = idx_t'(cr);
      res.col   = idx_t'(c);
      res.done  = 1'b0;
      res.peak  = '0;
      expected_results.push_back(res);
      emitted = 1'b1;
    end
    left_hold     = old_mid;
    above_row[c]  = old_mid;
    middle_row[c] = x;
    if (c >= s - 1) begin
      c = 0;
      if (r >= s - 1) begin
        if (!emitted) begin
          res.value = '0;
          res.row   = '0;
          res.col   = '0;
          res.done  = 1'b1;
          res.peak  = pass_peak[VW-1:0];
          expected_results.push_back(res);
        end
        r = 0;
        pass_peak = 0;
      end else begin
        r++;
      end
    end else begin
      c++;
    end
    row_pos = r;
    col_pos = c;
  endfunction

  function automatic logic signed [VW-1:0] rand_cell(input int unsigned bias);
    int unsigned          pick;
    logic signed [VW-1:0] v;
    pick = $urandom_range(0, 9);
    if (bias == 1 && pick < 7) return POS_MAX - $urandom_range(0, 255);
    if (bias == 2 && pick < 7) return NEG_MIN + $urandom_range(0, 255);
    if (bias == 3 && pick < 7) begin
      v = $urandom_range(0, 20'hFFFFF);
      return v - 32'sd524288;
    end
    if (pick == 0) begin
      case ($urandom_range(0, 4))
        0:       return POS_MAX;
        1:       return NEG_MIN;
        2:       return '0;
        3:       return '1;
        default: return 1;
      endcase
    end
    return $urandom();
  endfunction

  function automatic void check_field(input string name, input logic [VW-1:0] exp_v,
                                      input logic [VW-1:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, exp_v, got_v);
      mismatches++;
    end
  endfunction

  // result side: random stall after each item when stall_on is set, compare against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && sweep_ch.valid && sweep_ch.ready) begin
      result_hold = stall_on ? $urandom_range(0, 3) : 0;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h row %0d col %0d done %b",
                 $realtime, sweep_ch.new_value, sweep_ch.cell_row, sweep_ch.cell_col,
                 sweep_ch.pass_done);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("new_value", want.value, sweep_ch.new_value);
        check_field("cell_row", VW'(want.row), VW'(sweep_ch.cell_row));
        check_field("cell_col", VW'(want.col), VW'(sweep_ch.cell_col));
        check_field("pass_done", VW'(want.done), VW'(sweep_ch.pass_done));
        check_field("max_change", want.peak, sweep_ch.max_change);
      end
    end else if (result_hold > 0) begin
      result_hold--;
    end
    sweep_ch.ready <= rst_ni && (result_hold == 0);
  end

  task automatic send_cell(input logic signed [VW-1:0] value);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      cell_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cell_ch.valid      <= 1'b1;
    cell_ch.cell_value <= value;
    do @(posedge clk_i); while (!cell_ch.ready);
    predict_cell(value);
    cells_sent++;
  endtask

  task automatic wait_drained();
    cell_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_grid(input cfg_t g);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= g;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    grid_cfg = g;
    restart_sweep();
    idle_on  = ($urandom_range(0, 3) != 0);
    stall_on = ($urandom_range(0, 3) != 0);
  endtask

  task automatic test_reset_default();
    repeat (SIDE_MAX + 4) send_cell(rand_cell(0));
  endtask

  task automatic test_stencil_cases();
    logic signed [VW-1:0] pattern [25];
    pattern = '{
      '0,      POS_MAX, '0,      1,       '0,
      POS_MAX, POS_MAX, POS_MAX, -3,      2,
      '1,      POS_MAX, -7,      NEG_MIN, 5,
      '0,      9,       NEG_MIN, NEG_MIN, NEG_MIN,
      '0,      -2,      4,       NEG_MIN, '0
    };
    set_grid(cfg_t'(5));
    foreach (pattern[k]) send_cell(pattern[k]);
  endtask

  task automatic test_grid_limits();
    set_grid(cfg_t'(0));
    repeat (16) send_cell(rand_cell(0));
    set_grid(cfg_t'(3));
    repeat (16) send_cell(rand_cell(1));
    set_grid(cfg_t'(MIN_SIDE));
    repeat (32) send_cell(rand_cell(2));
    set_grid('1);
    repeat (32) send_cell(rand_cell(0));
  endtask

  task automatic test_random_sweeps();
    int unsigned target;
    int unsigned s;
    int unsigned passes;
    int unsigned tail;
    int unsigned bias;
    int unsigned burst;
    cfg_t        g;
    target = cells_sent + RANDOM_CELLS;
    while (cells_sent < target) begin
      case ($urandom_range(0, 9))
        0:       g = cfg_t'($urandom_range(0, 3));
        1:       g = cfg_t'($urandom_range(13, 24));
        default: g = cfg_t'($urandom_range(4, 12));
      endcase
      set_grid(g);
      s = grid_side();
      passes = (s > 12) ? $urandom_range(0, 1) : $urandom_range(0, 3);
      tail = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, s * s - 1);
      if (passes == 0 && tail == 0) passes = 1;
      bias = $urandom_range(0, 3);
      burst = passes * s * s + tail;
      if (burst > target - cells_sent) burst = target - cells_sent;
      repeat (burst) send_cell(rand_cell(bias));
    end
  endtask

  initial begin
    clk_i              = 1'b0;
    rst_ni             = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    cell_ch.valid      = 1'b0;
    cell_ch.cell_value = '0;
    sweep_ch.ready     = 1'b0;
    result_hold        = 0;
    mismatches         = 0;
    cells_sent         = 0;
    idle_on            = 1'b1;
    stall_on           = 1'b1;
    grid_cfg           = cfg_t'(GRID_RST);
    foreach (above_row[k]) begin
      above_row[k]  = '0;
      middle_row[k] = '0;
    end
    restart_sweep();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_default();
    test_stencil_cases();
    test_grid_limits();
    test_random_sweeps();
    wait_drained();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/jss_pkg.sv
src/jss_if.sv
src/jss_line_buf.sv
src/jss_divider.sv
src/jss_report.sv
src/jacobi_stencil_sweep.sv
src/jss_checker.sv
tb/jacobi_stencil_sweep_test.sv
